// ===== rtl/jmcm_pkg.sv =====
// Shared types and constants for the joint move completion monitor.
package jmcm_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	// Move status codes
	localparam logic [2:0] STS_EXEC    = 3'd0;
	localparam logic [2:0] STS_DONE    = 3'd1;
	localparam logic [2:0] STS_SLOW    = 3'd2;
	localparam logic [2:0] STS_MISSING = 3'd3;
	localparam logic [2:0] STS_STUCK   = 3'd4;
	localparam logic [2:0] STS_TIMEOUT = 3'd5;

	// Configuration register indexes
	localparam logic REG_TARGET_ANGLE = 1'b0;
	localparam logic REG_MAX_SPEED    = 1'b1;

	// Time limits in microseconds
	localparam logic [15:0] DT_MAX_US      = 16'd50000;
	localparam logic [26:0] HALF_SEC_US    = 27'd500000;
	localparam logic [26:0] TIMEOUT_MIN_US = 27'd2000000;
	localparam logic [26:0] TIMEOUT_MAX_US = 27'd60000000;
	localparam logic [17:0] SETTLE_US      = 18'd100000;
	localparam logic [21:0] STALL_US       = 22'd3000000;

	// Q16.16 thresholds
	localparam logic [31:0] MIN_SPEED_Q = 32'd572;
	localparam logic [32:0] POS_TOL_Q   = 33'd286;
	localparam logic [31:0] SPD_TOL_Q   = 32'd229;

	// Timeout scale: 3 s per rad/(rad/s), in microseconds
	localparam logic [21:0] TIMEOUT_SCALE = 22'd3000000;

	// Saturation limits
	localparam logic [25:0] ELAPSED_MAX = 26'h3FFFFFF;
	localparam logic [21:0] STALL_MAX   = 22'h3FFFFF;
	localparam logic [17:0] SETTLE_MAX  = 18'h3FFFF;
	localparam logic [31:0] BEST_NONE   = 32'hFFFFFFFF;
	localparam logic [31:0] TRACK_MAX   = 32'hFFFFFFFE;

	// Divider geometry
	localparam int unsigned DVD_W = 55;
	localparam logic [5:0]  DIV_LAST = 6'd54;

endpackage

// ===== rtl/joint_move_completion_monitor_top.sv =====
// Joint move completion monitor: tick supervisor with an iterative timeout divider.
// Sequence: a tick is evaluated and then emitted; a start, or the first request, with a valid joint
//   and speed also runs the restoring divider for its timeout, and a finishing step, before the emit.
// Throughput: one request at a time; s_tready rises again once the result is loaded into the
//   output register, and the load waits while the previous result has not been taken.
// Reset: arst_n clears the move state, the configuration registers and the output valid.
module joint_move_completion_monitor_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // [19:0] tick_us, [51:20] measured_angle,
	                              // [83:52] measured_speed, [87:84] zero
	input  logic [2:0]  s_tuser,  // [0] cmd, [1] angle_valid, [2] speed_valid
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [31:0] position_error, [57:32] elapsed_us, [63:58] zero
	output logic [2:0]  m_tuser   // [2:0] status
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [31:0] target_q;
	logic [31:0] max_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			max_speed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				jmcm_pkg::REG_TARGET_ANGLE: target_q    <= cfg_data;
				jmcm_pkg::REG_MAX_SPEED:    max_speed_q <= cfg_data;
				default:                    ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state and move state
	// ------------------------------------------------------------------
	jmcm_pkg::state_t state_q, state_nxt;

	logic        started_q;
	logic        finished_q;
	logic [2:0]  final_q;
	logic [25:0] elapsed_q;
	logic [17:0] settle_q;
	logic [21:0] stall_q;
	logic [31:0] best_q;
	logic [25:0] timeout_q;

	// captured request (payload, no reset)
	logic        cmd_q;
	logic [15:0] dt_q;
	logic [31:0] ang_q;
	logic [31:0] meas_spd_q;
	logic        aval_q;
	logic        sval_q;

	// divider registers
	logic [jmcm_pkg::DVD_W-1:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] div_spd_q;
	logic [25:0] quo_q;
	logic        ovf_q;
	logic [5:0]  cnt_q;

	// pending result
	logic [2:0]  res_status_q;
	logic [31:0] res_err_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_err_q;
	logic [25:0] out_elapsed_q;

	// control between sequencer and datapath
	typedef struct packed {
		logic accept;
		logic eval;
		logic div_step;
		logic fin;
		logic load_out;
	} ctl_t;
	ctl_t ctl;

	// ------------------------------------------------------------------
	// Request evaluation (combinational, used in ST_EVAL)
	// ------------------------------------------------------------------
	logic [15:0] dt_in;
	logic signed [32:0] err;
	logic [32:0] abs_err;
	logic [31:0] err_sat;
	logic [31:0] spd_abs;
	logic [31:0] om;
	logic        start_path;
	logic        speed_low;
	logic        need_div;
	logic [26:0] elapsed_sum;
	logic [25:0] elapsed_new;
	logic [22:0] stall_sum;
	logic [21:0] stall_sat;
	logic [21:0] stall_new;
	logic [18:0] settle_sum;
	logic [17:0] settle_sat;
	logic [17:0] settle_new;
	logic [31:0] trk;
	logic        progress;
	logic        in_tol;
	logic [2:0]  tick_status;
	logic [jmcm_pkg::DVD_W-1:0] prod;

	// clamp the step to 50 ms on capture
	assign dt_in = (s_tdata[19:0] > {4'b0, jmcm_pkg::DT_MAX_US}) ? jmcm_pkg::DT_MAX_US
	                                                              : s_tdata[15:0];

	assign err     = $signed({target_q[31], target_q}) - $signed({ang_q[31], ang_q});
	assign abs_err = err[32] ? 33'(-err) : 33'(err);
	assign err_sat = (err[32] != err[31]) ? (err[32] ? 32'h80000000 : 32'h7FFFFFFF)
	                                      : err[31:0];
	assign spd_abs = max_speed_q[31] ? (32'd0 - max_speed_q) : max_speed_q;
	assign om      = !sval_q ? 32'd0 : (meas_spd_q[31] ? (32'd0 - meas_spd_q) : meas_spd_q);

	assign start_path = cmd_q || !started_q;
	assign speed_low  = spd_abs < jmcm_pkg::MIN_SPEED_Q;
	assign need_div   = start_path && !speed_low && aval_q;

	// saturating timers
	assign elapsed_sum = {1'b0, elapsed_q} + {11'b0, dt_q};
	assign elapsed_new = elapsed_sum[26] ? jmcm_pkg::ELAPSED_MAX : elapsed_sum[25:0];
	assign stall_sum   = {1'b0, stall_q} + {7'b0, dt_q};
	assign stall_sat   = stall_sum[22] ? jmcm_pkg::STALL_MAX : stall_sum[21:0];
	assign settle_sum  = {1'b0, settle_q} + {3'b0, dt_q};
	assign settle_sat  = settle_sum[18] ? jmcm_pkg::SETTLE_MAX : settle_sum[17:0];

	// progress tracking: cap the error so the first tick always beats "none seen"
	assign trk        = (abs_err > {1'b0, jmcm_pkg::TRACK_MAX}) ? jmcm_pkg::TRACK_MAX
	                                                            : abs_err[31:0];
	assign progress   = trk < best_q;
	assign stall_new  = progress ? 22'd0 : stall_sat;
	assign in_tol     = (abs_err <= jmcm_pkg::POS_TOL_Q) && (om <= jmcm_pkg::SPD_TOL_Q);
	assign settle_new = in_tol ? settle_sat : 18'd0;

	always_comb begin
		priority if (!aval_q)
			tick_status = jmcm_pkg::STS_MISSING;
		else if (in_tol && (settle_sat >= jmcm_pkg::SETTLE_US))
			tick_status = jmcm_pkg::STS_DONE;
		else if (stall_new >= jmcm_pkg::STALL_US)
			tick_status = jmcm_pkg::STS_STUCK;
		else if (elapsed_new >= timeout_q)
			tick_status = jmcm_pkg::STS_TIMEOUT;
		else
			tick_status = jmcm_pkg::STS_EXEC;
	end

	// dividend for the timeout: |error| * 3e6
	assign prod = {22'b0, abs_err} * {33'b0, jmcm_pkg::TIMEOUT_SCALE};

	// ------------------------------------------------------------------
	// Divider step: one restoring subtract per cycle
	// ------------------------------------------------------------------
	logic [32:0] trial;
	logic        trial_ge;
	logic [32:0] trial_diff;

	assign trial      = {rem_q, dvd_q[jmcm_pkg::DVD_W-1]};
	assign trial_ge   = trial >= {1'b0, div_spd_q};
	assign trial_diff = trial - {1'b0, div_spd_q};

	// timeout = clamp(quotient + 0.5 s, 2 s, 60 s)
	logic [26:0] tsum;
	logic [25:0] timeout_new;

	assign tsum = {1'b0, quo_q} + jmcm_pkg::HALF_SEC_US;

	always_comb begin
		priority if (ovf_q || (tsum > jmcm_pkg::TIMEOUT_MAX_US))
			timeout_new = jmcm_pkg::TIMEOUT_MAX_US[25:0];
		else if (tsum < jmcm_pkg::TIMEOUT_MIN_US)
			timeout_new = jmcm_pkg::TIMEOUT_MIN_US[25:0];
		else
			timeout_new = tsum[25:0];
	end

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			jmcm_pkg::ST_IDLE: if (s_tvalid) state_nxt = jmcm_pkg::ST_EVAL;
			jmcm_pkg::ST_EVAL: state_nxt = need_div ? jmcm_pkg::ST_DIV : jmcm_pkg::ST_EMIT;
			jmcm_pkg::ST_DIV:  if (cnt_q == jmcm_pkg::DIV_LAST) state_nxt = jmcm_pkg::ST_FIN;
			jmcm_pkg::ST_FIN:  state_nxt = jmcm_pkg::ST_EMIT;
			jmcm_pkg::ST_EMIT: if (out_free) state_nxt = jmcm_pkg::ST_IDLE;
			default:           state_nxt = jmcm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: control outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			jmcm_pkg::ST_IDLE: ctl.accept   = s_tvalid;
			jmcm_pkg::ST_EVAL: ctl.eval     = 1'b1;
			jmcm_pkg::ST_DIV:  ctl.div_step = 1'b1;
			jmcm_pkg::ST_FIN:  ctl.fin      = 1'b1;
			jmcm_pkg::ST_EMIT: ctl.load_out = out_free;
			default:           ;
		endcase
	end

	assign s_tready = (state_q == jmcm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= jmcm_pkg::ST_IDLE;
		else         state_q <= state_nxt;
	end

	// ------------------------------------------------------------------
	// Capture the request
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q      <= s_tuser[0];
			aval_q     <= s_tuser[1];
			sval_q     <= s_tuser[2];
			dt_q       <= dt_in;
			ang_q      <= s_tdata[51:20];
			meas_spd_q <= s_tdata[83:52];
		end
	end

	// ------------------------------------------------------------------
	// Move state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			finished_q <= 1'b0;
			final_q    <= jmcm_pkg::STS_EXEC;
			elapsed_q  <= '0;
			settle_q   <= '0;
			stall_q    <= '0;
			best_q     <= jmcm_pkg::BEST_NONE;
			timeout_q  <= '0;
		end else if (ctl.eval) begin
			if (start_path) begin
				// restart the move from scratch
				started_q  <= 1'b1;
				finished_q <= speed_low || !aval_q;
				final_q    <= speed_low ? jmcm_pkg::STS_SLOW
				            : (!aval_q ? jmcm_pkg::STS_MISSING : jmcm_pkg::STS_EXEC);
				elapsed_q  <= '0;
				settle_q   <= '0;
				stall_q    <= '0;
				best_q     <= jmcm_pkg::BEST_NONE;
			end else if (!finished_q) begin
				elapsed_q <= elapsed_new;
				if (aval_q) begin
					if (progress) best_q <= trk;
					stall_q  <= stall_new;
					settle_q <= settle_new;
				end
				if (tick_status != jmcm_pkg::STS_EXEC) begin
					finished_q <= 1'b1;
					final_q    <= tick_status;
				end
			end
		end else if (ctl.fin) begin
			timeout_q <= timeout_new;
		end
	end

	// ------------------------------------------------------------------
	// Pending result
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			priority if (start_path) begin
				if (speed_low) begin
					res_status_q <= jmcm_pkg::STS_SLOW;
					res_err_q    <= aval_q ? err_sat : 32'd0;
				end else if (!aval_q) begin
					res_status_q <= jmcm_pkg::STS_MISSING;
					res_err_q    <= 32'd0;
				end else begin
					res_status_q <= jmcm_pkg::STS_EXEC;
					res_err_q    <= err_sat;
				end
			end else if (finished_q) begin
				// repeat the terminal status with the live error
				res_status_q <= final_q;
				res_err_q    <= aval_q ? err_sat : 32'd0;
			end else begin
				res_status_q <= tick_status;
				res_err_q    <= aval_q ? err_sat : 32'd0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Timeout divider
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			dvd_q     <= prod;
			rem_q     <= '0;
			quo_q     <= '0;
			ovf_q     <= 1'b0;
			div_spd_q <= spd_abs;
		end else if (ctl.div_step) begin
			rem_q <= trial_ge ? trial_diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[jmcm_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[24:0], trial_ge};
			ovf_q <= ovf_q | quo_q[25];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           cnt_q <= '0;
		else if (ctl.eval)     cnt_q <= '0;
		else if (ctl.div_step) cnt_q <= cnt_q + 6'd1;
	end

	// ------------------------------------------------------------------
	// Output register: hold until taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (ctl.load_out) out_valid_q <= 1'b1;
		else if (m_tready)     out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q  <= res_status_q;
			out_err_q     <= res_err_q;
			out_elapsed_q <= elapsed_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'b0, out_elapsed_q, out_err_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one still in progress");

	a_div_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jmcm_pkg::ST_DIV |-> cnt_q <= jmcm_pkg::DIV_LAST)
		else $error("divider ran past its last step");

	a_finished_implies_started: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> started_q)
		else $error("move finished without being started");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= jmcm_pkg::STS_TIMEOUT)
		else $error("result status code out of range");

endmodule

// ===== verif/jmcm_report_checker.sv =====
// Checker for the joint move monitor: tracks requests, predicts each report, compares results.
module jmcm_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,  // [19:0] tick_us, [51:20] measured_angle,
	                              // [83:52] measured_speed, [87:84] zero
	input  logic [2:0]  s_tuser,  // [0] cmd, [1] angle_valid, [2] speed_valid
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,  // [31:0] position_error, [57:32] elapsed_us, [63:58] zero
	input  logic [2:0]  m_tuser,  // [2:0] status
	output int          awaiting,
	output int          failures,
	output int          n_requests,
	output int          n_checked,
	output int          n_done,
	output int          n_stuck,
	output int          n_timeout
);

	localparam longint STEP_CAP_US   = 50000;
	localparam longint HALF_SECOND   = 500000;
	localparam longint TIMEOUT_FLOOR = 2000000;
	localparam longint TIMEOUT_CEIL  = 60000000;
	localparam longint SETTLE_NEED   = 100000;
	localparam longint STALL_LIMIT   = 3000000;
	localparam longint ELAPSED_SAT   = 64'h3FFFFFF;
	localparam longint SETTLE_SAT    = 64'h3FFFF;
	localparam longint STALL_SAT     = 64'h3FFFFF;
	localparam longint NO_ERROR_YET  = 64'hFFFFFFFF;
	localparam longint TRACK_CAP     = 64'hFFFFFFFE;
	localparam longint MIN_SPEED     = 572;
	localparam longint ANGLE_TOL     = 286;
	localparam longint RATE_TOL      = 229;
	localparam longint ERR_HI        = 64'sd2147483647;
	localparam longint ERR_LO        = -64'sd2147483648;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] pos_err;
		logic [25:0] elapsed;
	} move_report_t;

	logic signed [31:0] target_q;
	logic signed [31:0] speed_limit_q;
	bit                 moving;
	bit                 halted;
	logic [2:0]         held_status;
	longint             elapsed_us;
	longint             settle_us;
	longint             stall_us;
	longint             best_err;
	longint             timeout_us;
	move_report_t       expected_reports[$];

	function automatic longint sat_add(input longint a, input longint b, input longint cap);
		return (a + b > cap) ? cap : a + b;
	endfunction

	task automatic clear_move();
		halted      = 1'b0;
		held_status = jmcm_pkg::STS_EXEC;
		elapsed_us  = 0;
		settle_us   = 0;
		stall_us    = 0;
		best_err    = NO_ERROR_YET;
	endtask

	task automatic halt_move(input logic [2:0] st);
		halted      = 1'b1;
		held_status = st;
		if (st == jmcm_pkg::STS_DONE)
			n_done++;
		else if (st == jmcm_pkg::STS_STUCK)
			n_stuck++;
		else if (st == jmcm_pkg::STS_TIMEOUT)
			n_timeout++;
	endtask

	task automatic predict_report(input logic cmd, input logic [19:0] tick,
			input logic signed [31:0] ang, input logic signed [31:0] meas_rate,
			input logic ang_ok, input logic rate_ok, output move_report_t rpt);
		longint     err;
		longint     abs_err;
		longint     limit;
		longint     rate;
		longint     dt;
		longint     q;
		longint     trk;
		longint     shown;
		logic [2:0] st;
		bit         have_err;
		bit         settled;
		err      = longint'(target_q) - longint'(ang);
		abs_err  = (err < 0) ? -err : err;
		dt       = (tick > STEP_CAP_US) ? STEP_CAP_US : longint'(tick);
		have_err = 1'b1;
		st       = jmcm_pkg::STS_EXEC;
		if (cmd || !moving) begin
			limit = longint'(speed_limit_q);
			if (limit < 0)
				limit = -limit;
			moving = 1'b1;
			clear_move();
			if (limit < MIN_SPEED) begin
				st       = jmcm_pkg::STS_SLOW;
				have_err = ang_ok;
				halt_move(st);
			end else if (!ang_ok) begin
				st       = jmcm_pkg::STS_MISSING;
				have_err = 1'b0;
				halt_move(st);
			end else begin
				q = abs_err * 3000000 / limit + HALF_SECOND;
				if (q < TIMEOUT_FLOOR)
					q = TIMEOUT_FLOOR;
				if (q > TIMEOUT_CEIL)
					q = TIMEOUT_CEIL;
				timeout_us = q;
			end
		end else if (halted) begin
			st       = held_status;
			have_err = ang_ok;
		end else begin
			elapsed_us = sat_add(elapsed_us, dt, ELAPSED_SAT);
			if (!ang_ok) begin
				st       = jmcm_pkg::STS_MISSING;
				have_err = 1'b0;
				halt_move(st);
			end else begin
				rate = rate_ok ? longint'(meas_rate) : 0;
				if (rate < 0)
					rate = -rate;
				trk = (abs_err > TRACK_CAP) ? TRACK_CAP : abs_err;
				// progress means a strictly smaller error than any seen so far
				if (trk < best_err) begin
					best_err = trk;
					stall_us = 0;
				end else begin
					stall_us = sat_add(stall_us, dt, STALL_SAT);
				end
				settled = 1'b0;
				if (abs_err <= ANGLE_TOL && rate <= RATE_TOL) begin
					settle_us = sat_add(settle_us, dt, SETTLE_SAT);
					settled   = (settle_us >= SETTLE_NEED);
				end else begin
					settle_us = 0;
				end
				if (settled)
					st = jmcm_pkg::STS_DONE;
				else if (stall_us >= STALL_LIMIT)
					st = jmcm_pkg::STS_STUCK;
				else if (elapsed_us >= timeout_us)
					st = jmcm_pkg::STS_TIMEOUT;
				if (st != jmcm_pkg::STS_EXEC)
					halt_move(st);
			end
		end
		shown = have_err ? err : 0;
		if (shown > ERR_HI)
			shown = ERR_HI;
		if (shown < ERR_LO)
			shown = ERR_LO;
		rpt.status  = st;
		rpt.pos_err = shown[31:0];
		rpt.elapsed = elapsed_us[25:0];
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		failures++;
		$display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
			n_checked, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		move_report_t want;
		move_report_t fresh;
		if (!arst_n) begin
			target_q      = '0;
			speed_limit_q = '0;
			moving        = 1'b0;
			clear_move();
			timeout_us    = 0;
			expected_reports.delete();
			failures      = 0;
			n_requests    = 0;
			n_checked     = 0;
			n_done        = 0;
			n_stuck       = 0;
			n_timeout     = 0;
			awaiting     <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("unrequested result status", m_tuser, 0);
				end else begin
					want = expected_reports.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata[31:0] !== want.pos_err)
						report_mismatch("position_error", m_tdata[31:0], want.pos_err);
					if (m_tdata[57:32] !== want.elapsed)
						report_mismatch("elapsed_us", m_tdata[57:32], want.elapsed);
					n_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				predict_report(s_tuser[0], s_tdata[19:0], s_tdata[51:20], s_tdata[83:52],
					s_tuser[1], s_tuser[2], fresh);
				expected_reports.push_back(fresh);
				n_requests++;
			end
			if (cfg_we) begin
				if (cfg_idx == jmcm_pkg::REG_TARGET_ANGLE)
					target_q = cfg_data;
				else
					speed_limit_q = cfg_data;
			end
			awaiting <= expected_reports.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the joint move monitor testbench: clock, reset, stimulus, idling and verdict.
module testbench;

	// Request kinds carried in the cmd bit
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Guard against a hung handshake; a clean run needs far fewer cycles
	localparam int RUN_LIMIT = 1500000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_idx   = jmcm_pkg::REG_TARGET_ANGLE;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata   = '0;  // [19:0] tick_us, [51:20] measured_angle,
	                              // [83:52] measured_speed, [87:84] zero
	logic [2:0]  s_tuser   = '0;  // [0] cmd, [1] angle_valid, [2] speed_valid
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;         // [31:0] position_error, [57:32] elapsed_us, [63:58] zero
	logic [2:0]  m_tuser;         // [2:0] status

	int     awaiting;
	int     failures;
	int     n_requests;
	int     n_checked;
	int     n_done;
	int     n_stuck;
	int     n_timeout;
	int     tx_gap_pct   = 0;
	int     rx_stall_pct = 0;
	int     cycles       = 0;
	longint aim          = 0;   // target angle currently programmed, for shaping moves

	joint_move_completion_monitor_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	jmcm_report_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.awaiting   (awaiting),
		.failures   (failures),
		.n_requests (n_requests),
		.n_checked  (n_checked),
		.n_done     (n_done),
		.n_stuck    (n_stuck),
		.n_timeout  (n_timeout)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result side at the rate the current phase asks for
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Abort the run once the counter reaches RUN_LIMIT, as a guard against a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one request; insert random gaps first, then hold it until accepted.
	// Every call starts right after a rising edge, so each step sees one assignment.
	task automatic send_request(input logic cmd, input logic [19:0] dt, input logic [31:0] ang,
			input logic [31:0] rate, input logic aok, input logic sok);
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, rate, ang, dt};
		s_tuser  <= {sok, aok, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait until every predicted report has been seen on the result side
	task automatic drain_results();
		do @(posedge clk); while (awaiting != 0);
	endtask

	// Program target and speed limit once the block has gone quiet
	task automatic apply_setting(input logic [31:0] tgt, input logic [31:0] spd);
		s_tvalid <= 1'b0;
		drain_results();
		// a start reports only after its divide has finished, so this wait is only a margin
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= jmcm_pkg::REG_TARGET_ANGLE;
		cfg_data <= tgt;
		@(posedge clk);
		cfg_idx  <= jmcm_pkg::REG_MAX_SPEED;
		cfg_data <= spd;
		@(posedge clk);
		cfg_we   <= 1'b0;
		aim = longint'($signed(tgt));
	endtask

	// Measured angle that leaves the wanted error, clipped to the Q16.16 range
	function automatic logic [31:0] angle_for(input longint err);
		longint a;
		a = aim - err;
		if (a > 64'sd2147483647)
			a = 64'sd2147483647;
		if (a < -64'sd2147483648)
			a = -64'sd2147483648;
		return a[31:0];
	endfunction

	// One move: a start, then ticks shaped to settle, stall, drift into the timeout,
	// or just noise. Ticks past a terminal status exercise the held report.
	task automatic drive_move(inout int budget);
		int          kind;
		int          ticks;
		int          n;
		longint      err;
		logic [19:0] dt;
		logic [31:0] rate;
		logic        aok;
		logic        sok;
		logic        cmd;
		kind = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: err = longint'($urandom_range(0, 600)) - 300;
			1: err = longint'($urandom_range(0, 131072)) - 65536;
			2: err = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
			default: err = longint'($signed($urandom));
		endcase
		aok = (kind == 9) ? 1'($urandom_range(0, 1)) : 1'b1;
		send_request(CMD_START, 20'($urandom), angle_for(err), $urandom, aok,
			1'($urandom_range(0, 1)));
		budget--;
		if (kind < 5)
			ticks = $urandom_range(4, 30);
		else if (kind < 8)
			ticks = $urandom_range(45, 70);
		else
			ticks = $urandom_range(5, 20);
		for (n = 0; n < ticks && budget > 0; n++) begin
			dt  = ($urandom_range(0, 9) < 7) ? 20'd50000 : 20'($urandom);
			aok = ($urandom_range(0, 49) != 0);
			sok = ($urandom_range(0, 7) != 0);
			cmd = CMD_TICK;
			if (kind < 5) begin
				// halve the error, then hover around the tolerance band
				if (err > 300 || err < -300)
					err = err / 2;
				else
					err = longint'($urandom_range(0, 580)) - 290;
				if (err <= 300 && err >= -300)
					rate = 32'($urandom_range(0, 480)) - 32'd240;
				else
					rate = 32'($urandom_range(0, 1 << 16));
			end else if (kind < 7) begin
				// hold still away from the target: no progress
				rate = 32'($urandom_range(0, 2000)) - 32'd1000;
			end else if (kind == 7) begin
				// creep one LSB per tick: progress without arrival
				if (err > 0)
					err--;
				else if (err < 0)
					err++;
				rate = $urandom;
			end else begin
				err  = longint'($signed($urandom));
				rate = $urandom;
				dt   = 20'($urandom);
				aok  = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 9) == 0)
					cmd = CMD_START;
			end
			send_request(cmd, dt, angle_for(err), rate, aok, sok);
			budget--;
		end
	endtask

	initial begin
		int          ph;
		int          budget;
		logic [31:0] tgt;
		logic [31:0] spd;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 2 rad target at 1 rad/s
		apply_setting(32'h0002_0000, 32'h0001_0000);
		// a tick as the very first request still opens the move
		send_request(CMD_TICK, 20'd40000, 32'h0, 32'h100, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd0, 32'h0000_8000, 32'h0, 1'b1, 1'b1);
		// largest tick clamps to 50 ms; invalid speed is ignored
		send_request(CMD_TICK, 20'hFFFFF, 32'h0001_F000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		// settle on the edges of the angle and rate tolerance
		send_request(CMD_TICK, 20'd50000, 32'h0002_0000, -32'sd229, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h0002_011E, 32'd229, 1'b1, 1'b1);
		// held status after completion, with no angle and with a saturating error
		send_request(CMD_TICK, 20'd12345, 32'h0, 32'h0, 1'b0, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
		// start without a joint
		send_request(CMD_START, 20'd0, 32'h0, 32'h0, 1'b0, 1'b0);
		// far start clamps the timeout high, then the joint vanishes mid move
		send_request(CMD_START, 20'd50000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd30000, 32'h0002_0000, 32'h0, 1'b0, 1'b1);
		// zero error clamps the timeout low; restart while running
		send_request(CMD_START, 20'd1, 32'h0002_0000, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h0002_011F, 32'h0, 1'b1, 1'b1);
		send_request(CMD_START, 20'd50000, 32'h0001_0000, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h0001_8000, 32'hFFFF_FF1B, 1'b1, 1'b1);

		// Directed: speed limit one LSB below the minimum
		apply_setting(32'h0000_4000, 32'd571);
		send_request(CMD_START, 20'd50000, 32'h0, 32'h0, 1'b0, 1'b1);
		send_request(CMD_START, 20'd50000, 32'h0000_1000, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h0000_1000, 32'h0, 1'b1, 1'b1);

		// Directed: most negative target and speed limit, largest possible error
		apply_setting(32'h8000_0000, 32'h8000_0000);
		send_request(CMD_START, 20'd50000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);

		// Directed: largest target, speed limit exactly at the negative minimum
		apply_setting(32'h7FFF_FFFF, -32'sd572);
		send_request(CMD_START, 20'd50000, 32'h8000_0000, 32'h0, 1'b1, 1'b1);
		send_request(CMD_TICK, 20'd50000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);

		// Random moves: idling modes cycle while the setting changes per phase
		for (ph = 0; ph < 8; ph++) begin
			tgt = $urandom;
			case (ph)
				0: spd = 32'h0001_0000;
				1: begin tgt = 32'h7FFF_FFFF; spd = 32'h7FFF_FFFF; end
				2: begin tgt = 32'h8000_0000; spd = -32'sd572; end
				3: spd = -32'($urandom_range(572, 32'h40000));
				4: begin tgt = 32'h0; spd = 32'h8000_0000; end
				5: spd = 32'd571;
				6: spd = $urandom;
				default: begin tgt = 32'($urandom_range(0, 32'h40000)); spd = 32'h8000; end
			endcase
			apply_setting(tgt, spd);
			case (ph % 4)
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 52; rx_stall_pct = 0;  end
				2: begin tx_gap_pct = 0;  rx_stall_pct = 52; end
				default: begin tx_gap_pct = 23; rx_stall_pct = 23; end
			endcase
			// every start fails on the slow setting, so keep that phase short
			budget = (ph == 5) ? 40 : 170;
			while (budget > 0)
				drive_move(budget);
		end

		// Drop valid, collect the tail, then give the block a few quiet cycles
		s_tvalid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		$display("run covered %0d requests and %0d checked reports in 8 random phases",
			n_requests, n_checked);
		$display("moves settled %0d, stuck %0d, timed out %0d; %0d mismatches",
			n_done, n_stuck, n_timeout, failures);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
